[design/assert_macros.svh]
// assertion helpers for the rtl files, included by labmr_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: invariant violated");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication violated");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication violated");

`endif

[design/labmr_pkg.sv]
// ----------------------------------------------------------------------------
// labmr_pkg
// Shared constants, codes and types of the angular binning block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package labmr_pkg;

  localparam int MAX_BINS    = 4096;
  localparam int BIN_AW      = $clog2(MAX_BINS);
  localparam int BIN_NUM_W   = 12;
  localparam int TOTAL_W     = 13;
  localparam int COUNT_W     = 17;
  localparam int QUO_W       = 16;
  localparam int TURN_CD     = 36000;
  localparam int HALF_CIRCLE = 18000;
  localparam int ENTRY_W     = 25;
  localparam int JOBQ_DEPTH  = 2;
  localparam int OUTQ_DEPTH  = 2;

  localparam logic signed [16:0] WSTART_RST = -17'sd18000;
  localparam logic signed [16:0] WEND_RST   = 17'sd18000;
  localparam logic [7:0]         ROT_RST    = 8'd10;
  localparam logic [15:0]        PRATE_RST  = 16'd4000;

  typedef enum logic [1:0] {
    REG_WINDOW_START  = 2'd0,
    REG_WINDOW_END    = 2'd1,
    REG_ROTATION_RATE = 2'd2,
    REG_POINT_RATE    = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    JOB_READ = 2'd0,
    JOB_ADD  = 2'd1,
    JOB_NOTE = 2'd2
  } job_op_t;

  typedef struct packed {
    job_op_t              op;
    logic [BIN_NUM_W-1:0] index;
    logic [15:0]          range_mm;
    logic [7:0]           str;
    logic [TOTAL_W-1:0]   total;
    logic                 overflow;
    logic                 empty;
  } job_t;

  typedef struct packed {
    logic                 accepted;
    logic [BIN_NUM_W-1:0] bin_number;
    logic [15:0]          range_mm;
    logic [7:0]           strength;
    logic                 empty;
    logic [TOTAL_W-1:0]   total;
    logic                 overflow;
  } result_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_CNT_GO,
    F_CNT_WAIT,
    F_CLASSIFY,
    F_IDX_WAIT,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    D_IDLE,
    D_MUL,
    D_LOAD,
    D_STEP,
    D_DONE
  } div_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_WRITE
  } back_state_t;

endpackage

`default_nettype wire

[design/labmr_div.sv]
// ----------------------------------------------------------------------------
// labmr_div
// Iterative scaler: round(value * point_rate / (36000 * rotation_rate)),
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module labmr_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] value,
  input  logic [7:0]  rot,
  input  logic [15:0] prate,
  output logic        done,
  output logic [labmr_pkg::QUO_W-1:0] quotient
);
  import labmr_pkg::*;

  div_state_t state, state_next;
  logic [15:0]       val;
  logic [7:0]        rr;
  logic [15:0]       pr;
  logic [31:0]       prod;
  logic [23:0]       dd;
  logic [32:0]       rem;
  logic [39:0]       sh;
  logic [QUO_W-1:0]  quo;
  logic [3:0]        step;
  logic [39:0]       rem_ext;
  logic              ge;

  assign rem_ext = {7'b0, rem};
  assign ge      = rem_ext >= sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      D_IDLE: if (start) state_next = D_MUL;
      D_MUL:  state_next = D_LOAD;
      D_LOAD: state_next = D_STEP;
      D_STEP: if (step == 4'd0) state_next = D_DONE;
      D_DONE: state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  always_comb begin
    done     = (state == D_DONE);
    quotient = quo;
  end

  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        if (start) begin
          val <= value;
          rr  <= rot;
          pr  <= prate;
        end
      end
      D_MUL: begin
        prod <= {16'b0, val} * {16'b0, pr};
        dd   <= 24'(TURN_CD) * {16'b0, rr};
      end
      D_LOAD: begin
        // numerator 2*v*p + d, divisor 2*d aligned to the top quotient bit
        rem  <= {prod, 1'b0} + {9'b0, dd};
        sh   <= {dd, 1'b0, 15'b0};
        quo  <= '0;
        step <= 4'(QUO_W - 1);
      end
      D_STEP: begin
        if (ge) begin
          rem <= 33'(rem_ext - sh);
        end
        quo  <= {quo[QUO_W-2:0], ge};
        sh   <= sh >> 1;
        step <= step - 4'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[design/labmr_front.sv]
// ----------------------------------------------------------------------------
// labmr_front
// Accepts items, holds the window registers, works out the bin count and
// the bin index of a point, and hands a classified job to the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module labmr_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [16:0]           cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic                  kind,
  input  logic [15:0]           raw_angle,
  input  logic [15:0]           distance_mm,
  input  logic [7:0]            strength,
  input  logic [11:0]           read_index,
  input  logic                  hold,
  output logic                  job_push,
  output labmr_pkg::job_t       job,
  input  logic                  job_full
);
  import labmr_pkg::*;

  front_state_t state, state_next;

  logic signed [16:0] ws;
  logic signed [16:0] we;
  logic [7:0]         rot;
  logic [15:0]        prate;
  logic               dirty;
  logic [COUNT_W-1:0] count;

  logic               it_kind;
  logic [15:0]        it_angle;
  logic [15:0]        it_dist;
  logic [7:0]         it_str;
  logic [11:0]        it_ridx;

  logic               div_start;
  logic [15:0]        div_value;
  logic               div_done;
  logic [QUO_W-1:0]   quo;

  logic signed [17:0] span;
  logic               full_win;
  logic               cnt_zero;
  logic [15:0]        cnt_value;
  logic [15:0]        norm;
  logic signed [17:0] ws18;
  logic signed [17:0] wsm18;
  logic [16:0]        diff;
  logic [15:0]        ofs_full;
  logic signed [16:0] sgn;
  logic [17:0]        ofs_part18;
  logic               drop;
  logic [15:0]        offset;
  logic [TOTAL_W-1:0] total;
  logic [COUNT_W-1:0] idx;
  logic               accept;

  assign accept = push && !full;

  // window geometry
  assign span      = $signed({we[16], we}) - $signed({ws[16], ws});
  assign full_win  = span >= 18'sd36000;
  assign cnt_zero  = (rot == 8'd0) || (prate == 16'd0) || (!full_win && span[17]);
  assign cnt_value = full_win ? 16'(TURN_CD) : span[15:0];
  assign total     = (count > COUNT_W'(MAX_BINS)) ? TOTAL_W'(MAX_BINS) : count[TOTAL_W-1:0];

  // angle reduced into the circle
  assign norm = (it_angle >= 16'(TURN_CD)) ? 16'(it_angle - 16'(TURN_CD)) : it_angle;

  // window start reduced into the circle
  assign ws18 = $signed({ws[16], ws});
  always_comb begin
    if (ws18 < -18'sd36000) begin
      wsm18 = ws18 + 18'sd72000;
    end else if (ws18 < 18'sd0) begin
      wsm18 = ws18 + 18'sd36000;
    end else if (ws18 >= 18'sd36000) begin
      wsm18 = ws18 - 18'sd36000;
    end else begin
      wsm18 = ws18;
    end
  end

  assign diff     = {1'b0, norm} - {1'b0, wsm18[15:0]};
  assign ofs_full = diff[16] ? 16'(diff + 17'(TURN_CD)) : diff[15:0];

  // partial window works on the signed angle
  assign sgn        = $signed({1'b0, norm}) -
                      ((norm >= 16'(HALF_CIRCLE)) ? 17'sd36000 : 17'sd0);
  assign drop       = !full_win && ((sgn < ws) || (sgn > we));
  assign ofs_part18 = 18'($signed({sgn[16], sgn}) - $signed({ws[16], ws}));
  assign offset     = full_win ? ofs_full : ofs_part18[15:0];
  assign idx        = {1'b0, quo};

  labmr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .value    (div_value),
    .rot      (rot),
    .prate    (prate),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:     if (accept) state_next = dirty ? F_CNT_GO : F_CLASSIFY;
      F_CNT_GO:   state_next = cnt_zero ? F_CLASSIFY : F_CNT_WAIT;
      F_CNT_WAIT: if (div_done) state_next = F_CLASSIFY;
      F_CLASSIFY: begin
        if (!it_kind && count != '0 && !drop) begin
          state_next = F_IDX_WAIT;
        end else begin
          state_next = F_PUSH;
        end
      end
      F_IDX_WAIT: if (div_done) state_next = F_PUSH;
      F_PUSH:     if (!job_full) state_next = F_IDLE;
      default:    state_next = F_IDLE;
    endcase
  end

  always_comb begin
    full      = (state != F_IDLE) || hold;
    div_start = 1'b0;
    div_value = offset;
    job_push  = 1'b0;
    unique case (state)
      F_CNT_GO: begin
        div_start = !cnt_zero;
        div_value = cnt_value;
      end
      F_CLASSIFY: div_start = !it_kind && count != '0 && !drop;
      F_PUSH:     job_push = !job_full;
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ws    <= WSTART_RST;
      we    <= WEND_RST;
      rot   <= ROT_RST;
      prate <= PRATE_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW_START:  ws    <= $signed(cfg_data);
        REG_WINDOW_END:    we    <= $signed(cfg_data);
        REG_ROTATION_RATE: rot   <= cfg_data[7:0];
        REG_POINT_RATE:    prate <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // bin count is recomputed on the first item after reset or any register write
  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= 1'b1;
    end else if (cfg_write) begin
      dirty <= 1'b1;
    end else if ((state == F_CNT_GO && cnt_zero) || (state == F_CNT_WAIT && div_done)) begin
      dirty <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_CNT_GO && cnt_zero) begin
      count <= '0;
    end else if (state == F_CNT_WAIT && div_done) begin
      count <= idx + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_kind  <= kind;
      it_angle <= raw_angle;
      it_dist  <= distance_mm;
      it_str   <= strength;
      it_ridx  <= read_index;
    end
    if (state == F_CLASSIFY) begin
      job.range_mm <= it_dist;
      job.str      <= it_str;
      job.total    <= total;
      job.overflow <= 1'b0;
      job.empty    <= 1'b0;
      job.index    <= '0;
      job.op       <= JOB_NOTE;
      if (it_kind) begin
        job.index <= it_ridx;
        if ({5'b0, it_ridx} >= COUNT_W'(MAX_BINS)) begin
          job.overflow <= 1'b1;
          job.empty    <= 1'b1;
        end else begin
          job.op <= JOB_READ;
        end
      end
    end
    if (state == F_IDX_WAIT && div_done) begin
      if (idx >= count) begin
        job.op    <= JOB_NOTE;
        job.index <= '0;
      end else if (idx >= COUNT_W'(MAX_BINS)) begin
        job.op       <= JOB_NOTE;
        job.index    <= idx[BIN_NUM_W-1:0];
        job.overflow <= 1'b1;
      end else begin
        job.op    <= JOB_ADD;
        job.index <= idx[BIN_NUM_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

[design/labmr_job_queue.sv]
// ----------------------------------------------------------------------------
// labmr_job_queue
// Two-entry queue of classified jobs between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module labmr_job_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  labmr_pkg::job_t din,
  output logic            full,
  input  logic            pop,
  output labmr_pkg::job_t head,
  output logic            empty
);
  import labmr_pkg::*;

  localparam int PW = $clog2(JOBQ_DEPTH);

  job_t            slots [JOBQ_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  assign full  = count == (PW+1)'(JOBQ_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

[design/labmr_back.sv]
// ----------------------------------------------------------------------------
// labmr_back
// Bin store with read-modify-write per job, clearing sweep after reset,
// and a two-entry result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module labmr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_empty,
  input  labmr_pkg::job_t    job_head,
  output logic               job_pop,
  output logic               clearing,
  output logic               empty,
  input  logic               pop,
  output labmr_pkg::result_t result
);
  import labmr_pkg::*;

  localparam int OW = $clog2(OUTQ_DEPTH);

  back_state_t state, state_next;

  logic [ENTRY_W-1:0] store [MAX_BINS];
  logic [ENTRY_W-1:0] rd_data;
  logic [BIN_AW-1:0]  clr_addr;
  job_t               job;
  logic               mem_we;
  logic [BIN_AW-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               out_push;
  result_t            res;
  logic               valid;
  logic               nearer;

  result_t            out_slots [OUTQ_DEPTH];
  logic [OW-1:0]      out_wr;
  logic [OW-1:0]      out_rd;
  logic [OW:0]        out_count;

  assign valid  = rd_data[ENTRY_W-1];
  assign nearer = !valid || (job.range_mm < rd_data[23:8]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR: if (clr_addr == BIN_AW'(MAX_BINS - 1)) state_next = B_IDLE;
      B_IDLE:  if (job_pop) state_next = B_WRITE;
      B_WRITE: state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    clearing  = (state == B_CLEAR);
    job_pop   = (state == B_IDLE) && !job_empty && (out_count < (OW+1)'(OUTQ_DEPTH));
    out_push  = (state == B_WRITE);
    mem_we    = 1'b0;
    mem_waddr = job.index[BIN_AW-1:0];
    mem_wdata = {1'b1, job.range_mm, job.str};
    unique case (state)
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      B_WRITE: begin
        if (job.op == JOB_READ) begin
          mem_we    = 1'b1;
          mem_wdata = '0;
        end else if (job.op == JOB_ADD) begin
          mem_we = nearer;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res            = '0;
    res.bin_number = job.index;
    res.total      = job.total;
    case (job.op)
      JOB_READ: begin
        res.range_mm = valid ? rd_data[23:8] : 16'd0;
        res.strength = valid ? rd_data[7:0] : 8'd0;
        res.empty    = !valid;
      end
      JOB_ADD: res.accepted = 1'b1;
      default: begin
        res.empty    = job.empty;
        res.overflow = job.overflow;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == B_CLEAR) begin
      clr_addr <= clr_addr + BIN_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job     <= job_head;
      rd_data <= store[job_head.index[BIN_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
  end

  // result queue
  assign empty  = out_count == '0;
  assign result = out_slots[out_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr    <= '0;
      out_rd    <= '0;
      out_count <= '0;
    end else begin
      if (out_push) begin
        out_wr <= out_wr + OW'(1);
      end
      if (pop && !empty) begin
        out_rd <= out_rd + OW'(1);
      end
      out_count <= out_count + (OW+1)'(out_push) - (OW+1)'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_slots[out_wr] <= res;
    end
  end

  `ASSERT_ALWAYS(a_outq_bound, clk, rst, out_count <= (OW+1)'(OUTQ_DEPTH))
  `ASSERT_IMPLIES(a_no_job_while_clearing, clk, rst, state == B_CLEAR, !job_pop && empty)
  `ASSERT_NEXT(a_pop_leads_to_write, clk, rst, job_pop, state == B_WRITE && out_push)

endmodule

`default_nettype wire

[design/lidar_angular_bin_min_range.sv]
// ----------------------------------------------------------------------------
// lidar_angular_bin_min_range
// Angular binning of lidar points, keeping the nearest return per bin.
// ----------------------------------------------------------------------------
// Items are taken one at a time: full stays high until the front end has
// queued the job of the current item. An add item inside a non-empty window
// runs the bit-serial scaler (16 quotient steps plus setup) for its bin. The
// first item after reset or a register write first recomputes the bin count,
// on that scaler unless the count is zero. The back end reads the store as
// it pops a job and writes back, if at all, in B_WRITE; it pops no job while
// the result queue is full. After reset, full stays high while the bin store
// is cleared one entry per cycle; register writes are taken during that time.
`timescale 1ns / 1ps
`default_nettype none

module lidar_angular_bin_min_range (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        kind,
  input  logic [15:0] raw_angle,
  input  logic [15:0] distance_mm,
  input  logic [7:0]  strength,
  input  logic [11:0] read_index,
  output logic        empty,
  input  logic        pop,
  output logic        accepted,
  output logic [11:0] bin_number,
  output logic [15:0] bin_range_mm,
  output logic [7:0]  bin_strength,
  output logic        bin_empty,
  output logic [12:0] bin_total,
  output logic        overflow
);
  import labmr_pkg::*;

  job_t    job_in;
  job_t    job_head;
  logic    job_push;
  logic    job_full;
  logic    job_pop;
  logic    job_empty;
  logic    clearing;
  result_t result;

  labmr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .raw_angle   (raw_angle),
    .distance_mm (distance_mm),
    .strength    (strength),
    .read_index  (read_index),
    .hold        (clearing),
    .job_push    (job_push),
    .job         (job_in),
    .job_full    (job_full)
  );

  labmr_job_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .head  (job_head),
    .empty (job_empty)
  );

  labmr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job_head  (job_head),
    .job_pop   (job_pop),
    .clearing  (clearing),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  assign accepted     = result.accepted;
  assign bin_number   = result.bin_number;
  assign bin_range_mm = result.range_mm;
  assign bin_strength = result.strength;
  assign bin_empty    = result.empty;
  assign bin_total    = result.total;
  assign overflow     = result.overflow;

endmodule

`default_nettype wire
